// ===== hdl/wavhp_pkg.sv =====
package wavhp_pkg;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_ID,
		PH_LEN_FMT,
		PH_LEN_DATA,
		PH_LEN_OTHER,
		PH_FMT,
		PH_SKIP
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_NOT_RIFF,
		ST_NOT_PCM,
		ST_BAD_CH,
		ST_BAD_BITS,
		ST_ENDED,
		ST_NO_FMT
	} status_t;

	// Four-character codes as they appear after four little-endian byte shifts.
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [15:0] FMT_PCM    = 16'd1;
	localparam logic [15:0] CH_MONO    = 16'd1;
	localparam logic [15:0] CH_STEREO  = 16'd2;
	localparam logic [15:0] BITS_8     = 16'd8;
	localparam logic [15:0] BITS_16    = 16'd16;
	localparam logic [31:0] FMT_BYTES  = 32'd16;

	localparam logic [3:0] POS_WORD_END   = 4'd3;
	localparam logic [3:0] POS_FORMAT     = 4'd1;
	localparam logic [3:0] POS_RATE       = 4'd7;
	localparam logic [3:0] POS_WAVE       = 4'd11;
	localparam logic [3:0] POS_BITS       = 4'd15;

	localparam int TDATA_W = 72;

	typedef struct packed {
		logic       end_of_stream;
		logic       start_of_file;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [1:0]  channel_count;
		logic [31:0] sample_rate;
		logic [4:0]  bits_per_sample;
		logic [30:0] frame_count;
	} result_t;

endpackage

// ===== hdl/wavhp_in_stage.sv =====
module wavhp_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  wavhp_pkg::item_t s_item,
	input  logic            advance,
	output logic            valid_s1,
	output wavhp_pkg::item_t item_s1
);
	import wavhp_pkg::*;

	// The held transaction leaves in the same cycle that a new one may enter.
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= s_item;
		end
	end

endmodule

// ===== hdl/wavhp_core.sv =====
module wavhp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  wavhp_pkg::item_t  item,
	output logic              res_valid,
	output wavhp_pkg::result_t res
);
	import wavhp_pkg::*;

	phase_t      phase_q, cur_phase, nxt_phase;
	logic [3:0]  bif_q, cur_bif, nxt_bif;
	logic [31:0] shift_q, cur_shift, nxt_shift;
	logic [31:0] chunk_q, cur_chunk, nxt_chunk;
	logic [1:0]  ch_q, cur_ch, nxt_ch;
	logic [31:0] rate_q, cur_rate, nxt_rate;
	logic [4:0]  bits_q, cur_bits, nxt_bits;
	logic        fmt_seen_q, cur_fmt_seen, nxt_fmt_seen;
	logic        fin_q, cur_fin, nxt_fin;

	logic [31:0] shift_n;
	logic [15:0] upper;
	logic [3:0]  pos;
	logic [1:0]  sh;
	logic [31:0] shifted;
	logic [31:0] chunk_dec;

	// A start of file clears the parse before this byte is looked at.
	always_comb begin
		if (item.start_of_file) begin
			cur_phase    = PH_HEADER;
			cur_bif      = '0;
			cur_shift    = '0;
			cur_chunk    = '0;
			cur_ch       = '0;
			cur_rate     = '0;
			cur_bits     = '0;
			cur_fmt_seen = 1'b0;
			cur_fin      = 1'b0;
		end else begin
			cur_phase    = phase_q;
			cur_bif      = bif_q;
			cur_shift    = shift_q;
			cur_chunk    = chunk_q;
			cur_ch       = ch_q;
			cur_rate     = rate_q;
			cur_bits     = bits_q;
			cur_fmt_seen = fmt_seen_q;
			cur_fin      = fin_q;
		end
	end

	assign shift_n   = {item.data_byte, cur_shift[31:8]};
	assign upper     = shift_n[31:16];
	assign pos       = cur_bif;
	assign sh        = {1'b0, cur_ch == 2'd2} + {1'b0, cur_bits == 5'd16};
	assign shifted   = shift_n >> sh;
	assign chunk_dec = cur_chunk - 32'd1;

	// Result of this byte.
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (item.end_of_stream) begin
			if (!cur_fin) begin
				res_valid  = 1'b1;
				res.status = ST_ENDED;
			end
		end else if (!cur_fin) begin
			unique case (cur_phase)
				PH_HEADER: begin
					if ((pos == POS_WORD_END && shift_n != TAG_RIFF) ||
					    (pos == POS_WAVE && shift_n != TAG_WAVE)) begin
						res_valid  = 1'b1;
						res.status = ST_NOT_RIFF;
					end
				end
				PH_LEN_DATA: begin
					if (pos == POS_WORD_END) begin
						res_valid = 1'b1;
						if (!cur_fmt_seen) begin
							res.status = ST_NO_FMT;
						end else begin
							res.status          = ST_OK;
							res.channel_count   = cur_ch;
							res.sample_rate     = cur_rate;
							res.bits_per_sample = cur_bits;
							res.frame_count     = shift_n[31] ? '0 : shifted[30:0];
						end
					end
				end
				PH_FMT: begin
					if (pos == POS_FORMAT && upper != FMT_PCM) begin
						res_valid  = 1'b1;
						res.status = ST_NOT_PCM;
					end else if (pos == POS_WORD_END && upper != CH_MONO &&
					             upper != CH_STEREO) begin
						res_valid  = 1'b1;
						res.status = ST_BAD_CH;
					end else if (pos == POS_BITS && upper != BITS_8 &&
					             upper != BITS_16) begin
						res_valid  = 1'b1;
						res.status = ST_BAD_BITS;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Next parse state.
	always_comb begin
		nxt_phase    = cur_phase;
		nxt_bif      = cur_bif;
		nxt_shift    = cur_shift;
		nxt_chunk    = cur_chunk;
		nxt_ch       = cur_ch;
		nxt_rate     = cur_rate;
		nxt_bits     = cur_bits;
		nxt_fmt_seen = cur_fmt_seen;
		nxt_fin      = cur_fin || res_valid;
		if (!item.end_of_stream && !cur_fin) begin
			nxt_shift = shift_n;
			nxt_bif   = pos + 4'd1;
			unique case (cur_phase) inside
				PH_HEADER: begin
					if (pos == POS_WAVE) begin
						nxt_phase = PH_ID;
						nxt_bif   = '0;
					end
				end
				PH_ID: begin
					if (pos == POS_WORD_END) begin
						nxt_bif = '0;
						if (shift_n == TAG_FMT) begin
							nxt_phase = PH_LEN_FMT;
						end else if (shift_n == TAG_DATA) begin
							nxt_phase = PH_LEN_DATA;
						end else begin
							nxt_phase = PH_LEN_OTHER;
						end
					end
				end
				PH_LEN_FMT, PH_LEN_DATA, PH_LEN_OTHER: begin
					if (pos == POS_WORD_END) begin
						nxt_chunk = shift_n;
						nxt_bif   = '0;
						if (cur_phase == PH_LEN_FMT) begin
							nxt_phase = PH_FMT;
						end else if (cur_phase == PH_LEN_OTHER) begin
							nxt_phase = (!shift_n[31] && shift_n != '0) ? PH_SKIP : PH_ID;
						end
					end
				end
				PH_FMT: begin
					if (pos == POS_WORD_END) begin
						nxt_ch = upper[1:0];
					end
					if (pos == POS_RATE) begin
						nxt_rate = shift_n;
					end
					if (pos == POS_BITS) begin
						nxt_bits     = upper[4:0];
						nxt_fmt_seen = 1'b1;
						nxt_bif      = '0;
						if (!cur_chunk[31] && cur_chunk > FMT_BYTES) begin
							nxt_chunk = cur_chunk - FMT_BYTES;
							nxt_phase = PH_SKIP;
						end else begin
							nxt_phase = PH_ID;
						end
					end
				end
				PH_SKIP: begin
					nxt_bif   = '0;
					nxt_chunk = chunk_dec;
					if (chunk_dec == '0) begin
						nxt_phase = PH_ID;
					end
				end
				default: begin
					nxt_phase = PH_ID;
					nxt_bif   = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			bif_q      <= '0;
			shift_q    <= '0;
			chunk_q    <= '0;
			ch_q       <= '0;
			rate_q     <= '0;
			bits_q     <= '0;
			fmt_seen_q <= 1'b0;
			fin_q      <= 1'b0;
		end else if (step_en) begin
			phase_q    <= nxt_phase;
			bif_q      <= nxt_bif;
			shift_q    <= nxt_shift;
			chunk_q    <= nxt_chunk;
			ch_q       <= nxt_ch;
			rate_q     <= nxt_rate;
			bits_q     <= nxt_bits;
			fmt_seen_q <= nxt_fmt_seen;
			fin_q      <= nxt_fin;
		end
	end

	a_result_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res_valid |=> fin_q)
		else $error("parse not marked finished after a result");

	a_quiet_when_finished: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q && !item.start_of_file |-> !res_valid)
		else $error("result produced after the parse had finished");

	a_ok_has_format: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == ST_OK |-> fmt_seen_q && res.channel_count != 2'd0)
		else $error("ok result without a valid format");

endmodule

// ===== hdl/wavhp_out_stage.sv =====
module wavhp_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  wavhp_pkg::result_t  res,
	output logic                out_free,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [wavhp_pkg::TDATA_W-1:0] m_tdata,
	output logic [2:0]          m_tuser
);
	import wavhp_pkg::*;

	result_t res_q;

	assign out_free = !m_tvalid || m_tready;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {2'b00, res_q.frame_count, res_q.bits_per_sample,
	                   res_q.sample_rate, res_q.channel_count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("result register loaded while still holding a result");

endmodule

// ===== hdl/wav_header_parser.sv =====
// A result is presented on m_tvalid once the byte that completes it has been accepted and
// has passed the input register, then the parse logic into the result register.
// Throughput: one byte per cycle; ready falls only while a finished result waits
// in the result register and another byte is already held in the input register.
// Reset (arst_n low) clears the parse to the start of the RIFF header and empties both registers.
module wav_header_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // data_byte[7:0]
	input  logic                          s_tuser,  // start_of_file
	input  logic                          s_tlast,  // end_of_stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// channel_count[1:0], sample_rate[33:2], bits_per_sample[38:34],
	// frame_count[69:39], zero fill [71:70]
	output logic [wavhp_pkg::TDATA_W-1:0] m_tdata,
	output logic [2:0]                    m_tuser   // status[2:0]
);
	import wavhp_pkg::*;

	item_t   s_item, item_s1;
	result_t res;
	logic    valid_s1, out_free, step_en, res_valid;

	assign s_item  = '{end_of_stream: s_tlast, start_of_file: s_tuser, data_byte: s_tdata};
	assign step_en = valid_s1 && out_free;

	wavhp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_item   (s_item),
		.advance  (step_en),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	wavhp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	wavhp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step_en && res_valid),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import wavhp_pkg::*;

	logic                 clk;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata  = '0;  // data_byte[7:0]
	logic                 s_tuser  = 1'b0; // start_of_file
	logic                 s_tlast  = 1'b0; // end_of_stream
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// channel_count[1:0], sample_rate[33:2], bits_per_sample[38:34],
	// frame_count[69:39], zero fill [71:70]
	logic [TDATA_W-1:0]   m_tdata;
	logic [2:0]           m_tuser;  // status[2:0]

	// Parser state as the predictor tracks it.
	phase_t      walk_phase;
	logic [3:0]  byte_pos;
	logic [31:0] shift_word;
	logic [31:0] chunk_left;
	logic [15:0] fmt_channels;
	logic [31:0] fmt_rate;
	logic [15:0] fmt_bits;
	bit          fmt_valid;
	bit          parse_done;

	result_t awaited_reports[$];
	int      bytes_sent = 0;
	int      fail_count = 0;
	int      gap_pct = 0;
	int      stall_pct = 0;
	int      hold_left = 0;

	wav_header_parser DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic void parser_clear();
		walk_phase   = PH_HEADER;
		byte_pos     = '0;
		shift_word   = '0;
		chunk_left   = '0;
		fmt_channels = '0;
		fmt_rate     = '0;
		fmt_bits     = '0;
		fmt_valid    = 1'b0;
		parse_done   = 1'b0;
	endfunction

	function automatic bit end_with(input status_t st, output result_t res);
		res = '0;
		res.status = st;
		parse_done = 1'b1;
		return 1'b1;
	endfunction

	// Advances the predicted parse by one byte; returns 1 when a report is due.
	function automatic bit predict_header_byte(input item_t it, output result_t res);
		logic [3:0]  pos;
		logic [15:0] upper;
		logic [31:0] frames;
		int          shift_amt;
		res = '0;
		if (it.start_of_file)
			parser_clear();
		if (it.end_of_stream) begin
			if (parse_done)
				return 1'b0;
			return end_with(ST_ENDED, res);
		end
		if (parse_done)
			return 1'b0;

		shift_word = {it.data_byte, shift_word[31:8]};
		pos = byte_pos;
		byte_pos = pos + 4'd1;
		upper = shift_word[31:16];

		case (walk_phase)
		PH_HEADER: begin
			if (pos == POS_WORD_END && shift_word != TAG_RIFF)
				return end_with(ST_NOT_RIFF, res);
			if (pos == POS_WAVE) begin
				if (shift_word != TAG_WAVE)
					return end_with(ST_NOT_RIFF, res);
				walk_phase = PH_ID;
				byte_pos = '0;
			end
		end
		PH_ID: begin
			if (pos == POS_WORD_END) begin
				if (shift_word == TAG_FMT)
					walk_phase = PH_LEN_FMT;
				else if (shift_word == TAG_DATA)
					walk_phase = PH_LEN_DATA;
				else
					walk_phase = PH_LEN_OTHER;
				byte_pos = '0;
			end
		end
		PH_LEN_FMT, PH_LEN_DATA, PH_LEN_OTHER: begin
			if (pos == POS_WORD_END) begin
				chunk_left = shift_word;
				byte_pos = '0;
				if (walk_phase == PH_LEN_FMT) begin
					walk_phase = PH_FMT;
				end else if (walk_phase == PH_LEN_OTHER) begin
					walk_phase = (!chunk_left[31] && chunk_left != 0) ? PH_SKIP : PH_ID;
				end else if (!fmt_valid) begin
					return end_with(ST_NO_FMT, res);
				end else begin
					// Bytes per frame is 1, 2 or 4, so the division is a shift.
					shift_amt = int'(fmt_channels == CH_STEREO) + int'(fmt_bits == BITS_16);
					frames = chunk_left[31] ? 32'd0 : (chunk_left >> shift_amt);
					res.status          = ST_OK;
					res.channel_count   = fmt_channels[1:0];
					res.sample_rate     = fmt_rate;
					res.bits_per_sample = fmt_bits[4:0];
					res.frame_count     = frames[30:0];
					parse_done = 1'b1;
					return 1'b1;
				end
			end
		end
		PH_FMT: begin
			if (pos == POS_FORMAT && upper != FMT_PCM)
				return end_with(ST_NOT_PCM, res);
			if (pos == POS_WORD_END) begin
				if (upper != CH_MONO && upper != CH_STEREO)
					return end_with(ST_BAD_CH, res);
				fmt_channels = upper;
			end
			if (pos == POS_RATE)
				fmt_rate = shift_word;
			if (pos == POS_BITS) begin
				if (upper != BITS_8 && upper != BITS_16)
					return end_with(ST_BAD_BITS, res);
				fmt_bits = upper;
				fmt_valid = 1'b1;
				byte_pos = '0;
				if (!chunk_left[31] && chunk_left > FMT_BYTES) begin
					chunk_left = chunk_left - FMT_BYTES;
					walk_phase = PH_SKIP;
				end else begin
					walk_phase = PH_ID;
				end
			end
		end
		PH_SKIP: begin
			byte_pos = '0;
			chunk_left = chunk_left - 32'd1;
			if (chunk_left == 0)
				walk_phase = PH_ID;
		end
		default: begin
			walk_phase = PH_ID;
			byte_pos = '0;
		end
		endcase
		return 1'b0;
	endfunction

	// Receiver: random stalls, or a long hold-off while hold_left counts down.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Outputs are sampled mid-cycle; the transaction completes at the next rising edge.
	always @(negedge clk) begin : report_check
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_reports.size() == 0) begin
				$error("unexpected report: status %0d", m_tuser);
				fail_count++;
			end else begin
				want = awaited_reports.pop_front();
				check_field("status", 32'(want.status), 32'(m_tuser));
				check_field("channel_count", 32'(want.channel_count), 32'(m_tdata[1:0]));
				check_field("sample_rate", want.sample_rate, m_tdata[33:2]);
				check_field("bits_per_sample", 32'(want.bits_per_sample),
					32'(m_tdata[38:34]));
				check_field("frame_count", 32'(want.frame_count), 32'(m_tdata[69:39]));
			end
		end
	end

	task automatic send_item(input logic [7:0] data, input logic sof, input logic eos);
		item_t   it;
		result_t res;
		bit      taken;
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= sof;
		s_tlast  <= eos;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		it.data_byte     = data;
		it.start_of_file = sof;
		it.end_of_stream = eos;
		if (predict_header_byte(it, res))
			awaited_reports.push_back(res);
		bytes_sent++;
	endtask

	task automatic send_word(input logic [31:0] w, input bit first);
		for (int i = 0; i < 4; i++)
			send_item(w[8*i +: 8], first && i == 0, 1'b0);
	endtask

	task automatic send_riff(input logic [31:0] riff, input logic [31:0] wave);
		send_word(riff, 1'b1);
		send_word($urandom, 1'b0);
		send_word(wave, 1'b0);
	endtask

	// A fmt chunk: format, channels, rate, byte rate, block align, bits, then any padding.
	task automatic send_fmt(input logic [31:0] len, input logic [15:0] fmt_code,
			input logic [15:0] chans, input logic [31:0] rate, input logic [15:0] bits);
		int extra;
		send_word(TAG_FMT, 1'b0);
		send_word(len, 1'b0);
		send_word({chans, fmt_code}, 1'b0);
		send_word(rate, 1'b0);
		send_word($urandom, 1'b0);
		send_word({bits, 16'($urandom)}, 1'b0);
		extra = (!len[31] && len > FMT_BYTES) ? int'(len - FMT_BYTES) : 0;
		repeat (extra) send_item(8'($urandom), 1'b0, 1'b0);
	endtask

	task automatic send_chunk(input logic [31:0] id, input logic [31:0] len, input int body);
		send_word(id, 1'b0);
		send_word(len, 1'b0);
		repeat (body) send_item(8'($urandom), 1'b0, 1'b0);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_header_checks();
		// A bad tag is reported on its last byte; the rest of the header is ignored.
		send_riff(TAG_RIFF ^ 32'h8000_0000, TAG_WAVE);
		send_riff(TAG_RIFF, TAG_WAVE ^ 32'h0000_000F);
		send_riff(32'h0000_0000, 32'hFFFF_FFFF);
	endtask

	task automatic test_field_checks();
		send_riff(TAG_RIFF, TAG_WAVE);
		send_fmt(FMT_BYTES, 16'd3, CH_MONO, 32'd44100, BITS_8);
		send_riff(TAG_RIFF, TAG_WAVE);
		send_fmt(FMT_BYTES, 16'h0101, CH_MONO, 32'd44100, BITS_8);
		send_riff(TAG_RIFF, TAG_WAVE);
		send_fmt(FMT_BYTES, FMT_PCM, 16'd0, 32'd44100, BITS_8);
		send_riff(TAG_RIFF, TAG_WAVE);
		send_fmt(FMT_BYTES, FMT_PCM, 16'h0102, 32'd44100, BITS_8);
		send_riff(TAG_RIFF, TAG_WAVE);
		send_fmt(FMT_BYTES, FMT_PCM, CH_STEREO, 32'd44100, 16'd24);
		send_riff(TAG_RIFF, TAG_WAVE);
		send_fmt(FMT_BYTES, FMT_PCM, CH_MONO, 32'd44100, 16'h0108);
	endtask

	task automatic test_chunk_walk();
		send_riff(TAG_RIFF, TAG_WAVE);
		send_fmt(FMT_BYTES, FMT_PCM, CH_MONO, 32'd0, BITS_8);
		send_chunk(TAG_DATA, 32'd0, 0);
		// Padded fmt, then unknown chunks of positive, zero and negative length.
		send_riff(TAG_RIFF, TAG_WAVE);
		send_fmt(32'd18, FMT_PCM, CH_STEREO, 32'hFFFF_FFFF, BITS_16);
		send_chunk(32'h5453_494C, 32'd3, 3);
		send_chunk(32'h6B6E_756A, 32'd0, 0);
		send_chunk(32'h6B6E_756A, 32'hFFFF_FFFF, 0);
		send_chunk(TAG_DATA, 32'h7FFF_FFFF, 0);
		// Short fmt: no skip, and a negative data length saturates to zero frames.
		send_riff(TAG_RIFF, TAG_WAVE);
		send_fmt(32'd10, FMT_PCM, CH_MONO, 32'd22050, BITS_16);
		send_chunk(TAG_DATA, 32'h8000_0000, 0);
		// The second fmt chunk replaces the first.
		send_riff(TAG_RIFF, TAG_WAVE);
		send_fmt(FMT_BYTES, FMT_PCM, CH_MONO, 32'd8000, BITS_16);
		send_fmt(FMT_BYTES, FMT_PCM, CH_STEREO, 32'd48000, BITS_8);
		send_chunk(TAG_DATA, 32'd1001, 0);
	endtask

	task automatic test_stream_control();
		send_riff(TAG_RIFF, TAG_WAVE);
		send_chunk(TAG_DATA, 32'd100, 0);
		// Once reported, bytes and end markers are ignored until the next file.
		repeat (4) send_item(8'($urandom), 1'b0, 1'b0);
		send_item(8'($urandom), 1'b0, 1'b1);
		send_riff(TAG_RIFF, TAG_WAVE);
		send_word(TAG_FMT, 1'b0);
		send_item(8'($urandom), 1'b0, 1'b1);
		// A restart in mid-header abandons the partial parse.
		send_riff(TAG_RIFF, TAG_WAVE);
		send_word(TAG_FMT, 1'b0);
		send_riff(TAG_RIFF, TAG_WAVE);
		send_fmt(FMT_BYTES, FMT_PCM, CH_MONO, 32'd11025, BITS_16);
		send_chunk(TAG_DATA, 32'd64, 0);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
	endtask

	task automatic test_backpressure();
		gap_pct = 0;
		stall_pct = 0;
		hold_left = 300;
		repeat (6) send_riff(TAG_RIFF ^ 32'h0000_0001, TAG_WAVE);
		send_riff(TAG_RIFF, TAG_WAVE);
		send_fmt(FMT_BYTES, FMT_PCM, CH_STEREO, 32'd96000, BITS_16);
		send_chunk(TAG_DATA, 32'd4096, 0);
		wait_drained();
	endtask

	// Mostly well-formed files with random content, plus corrupt headers and noise.
	task automatic random_file();
		int          pick;
		logic [31:0] len;
		logic [15:0] fmt_code;
		logic [15:0] chans;
		logic [15:0] bits;
		pick = $urandom_range(99);
		if (pick < 6) begin
			repeat ($urandom_range(1, 8))
				send_item(8'($urandom), $urandom_range(9) == 0, $urandom_range(14) == 0);
			return;
		end
		send_riff(pick < 10 ? TAG_RIFF ^ (32'd1 << $urandom_range(31)) : TAG_RIFF,
			(pick >= 10 && pick < 14) ? TAG_WAVE ^ (32'd1 << $urandom_range(31)) : TAG_WAVE);
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(1)) begin
				case ($urandom_range(9))
				0: len = $urandom_range(0, 15);
				1: len = $urandom_range(17, 24);
				2: len = 32'h8000_0000 | $urandom;
				default: len = FMT_BYTES;
				endcase
				fmt_code = ($urandom_range(19) == 0) ? 16'($urandom) : FMT_PCM;
				chans = $urandom_range(1) ? CH_STEREO : CH_MONO;
				if ($urandom_range(9) == 0)
					chans = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 3));
				bits = $urandom_range(1) ? BITS_16 : BITS_8;
				if ($urandom_range(9) == 0)
					bits = 16'($urandom);
				send_fmt(len, fmt_code, chans, $urandom, bits);
			end else begin
				case ($urandom_range(4))
				0: len = 32'd0;
				1: len = 32'h8000_0000 | $urandom;
				default: len = $urandom_range(1, 6);
				endcase
				send_chunk($urandom, len, len[31] ? 0 : int'(len));
			end
		end
		if ($urandom_range(99) < 85) begin
			case ($urandom_range(3))
			0: len = $urandom;
			1: len = $urandom_range(0, 4000);
			2: len = 32'h7FFF_FFFF;
			default: len = 32'h8000_0000 | $urandom;
			endcase
			send_chunk(TAG_DATA, len, 0);
		end
		repeat ($urandom_range(0, 3)) send_item(8'($urandom), 1'b0, 1'b0);
		if ($urandom_range(2) == 0)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic test_random_traffic(input int send_gap, input int recv_stall, input int n_bytes);
		int first_byte;
		gap_pct = send_gap;
		stall_pct = recv_stall;
		first_byte = bytes_sent;
		while (bytes_sent - first_byte < n_bytes)
			random_file();
		wait_drained();
	endtask

	initial begin
		parser_clear();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_checks();
		test_field_checks();
		test_chunk_walk();
		test_stream_control();
		wait_drained();
		test_backpressure();
		test_random_traffic(0, 0, 20);
		test_random_traffic(62, 0, 20);
		test_random_traffic(0, 62, 20);
		test_random_traffic(35, 35, 20);
		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/wavhp_pkg.sv
hdl/wavhp_in_stage.sv
hdl/wavhp_core.sv
hdl/wavhp_out_stage.sv
hdl/wav_header_parser.sv
test/tb_top.sv
